// ===== rtl/rpca_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Relocation patch command apply: shared types and constants
// Opcodes, status codes, register indexes and the beat structures passed
// between the top level and the merge logic.
// ----------------------------------------------------------------------------
package rpca_pkg;

    localparam logic [7:0] OP_ADDR32      = 8'd1;
    localparam logic [7:0] OP_ADDR16_LO   = 8'd4;
    localparam logic [7:0] OP_ADDR16_HI   = 8'd5;
    localparam logic [7:0] OP_ADDR16_HA   = 8'd6;
    localparam logic [7:0] OP_REL24       = 8'd10;
    localparam logic [7:0] OP_WRITE32     = 8'd32;
    localparam logic [7:0] OP_WRITE16     = 8'd33;
    localparam logic [7:0] OP_WRITE8      = 8'd34;
    localparam logic [7:0] OP_COND_PTR    = 8'd35;
    localparam logic [7:0] OP_COND32      = 8'd36;
    localparam logic [7:0] OP_COND16      = 8'd37;
    localparam logic [7:0] OP_COND8       = 8'd38;
    localparam logic [7:0] OP_BRANCH      = 8'd64;
    localparam logic [7:0] OP_BRANCH_LINK = 8'd65;

    localparam logic [1:0] CFG_TEXT_BASE  = 2'd0;
    localparam logic [1:0] CFG_SPLIT_ADDR = 2'd1;
    localparam logic [1:0] CFG_FIRST_PASS = 2'd2;

    localparam logic [31:0] TEXT_BASE_RST  = 32'h0000_0000;
    localparam logic [31:0] SPLIT_ADDR_RST = 32'h8050_BF50;

    localparam logic [23:0] MARK_EXTENDED = 24'hFF_FFFE;
    localparam logic [31:0] KEEP_BITS     = 32'hFC00_0003;
    localparam logic [31:0] DISP_BITS     = 32'h03FF_FFFC;
    localparam logic [31:0] INSN_B        = 32'h4800_0000;
    localparam logic [31:0] INSN_BL       = 32'h4800_0001;
    localparam logic [31:0] HA_ROUND      = 32'h0000_8000;

    localparam int unsigned IN_TDATA_W   = 160;
    localparam int unsigned OUT_TDATA_W  = 72;
    localparam int unsigned OUT_TUSER_W  = 3;

    typedef enum logic [1:0] {
        ST_APPLIED = 2'd0,
        ST_SKIPPED = 2'd1,
        ST_UNKNOWN = 2'd2
    } t_status;

    typedef struct packed {
        logic [31:0] text_base;
        logic [31:0] split_address;
        logic        first_pass;
    } t_cfg;

    typedef struct packed {
        logic [31:0] current_word;
        logic [31:0] payload_original;
        logic [31:0] payload_value;
        logic [31:0] long_address;
        logic [23:0] short_address;
        logic [7:0]  opcode;
    } t_cmd;

    typedef struct packed {
        t_status     status;
        logic        write_enable;
        logic [31:0] target_address;
        logic [31:0] write_data;
        logic [3:0]  byte_enable;
        logic [1:0]  payload_words;
    } t_res;

endpackage

// ===== rtl/rpca_merge.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Relocation patch command apply: merge logic
// Resolves the target, applies the pass filter and builds the merged word,
// byte lanes, payload word count and status for one command.
// ----------------------------------------------------------------------------
module rpca_merge
    import rpca_pkg::*;
(
    input  t_cfg i_cfg,
    input  t_cmd i_cmd,
    output t_res o_res
);

    logic [1:0]  pw;
    logic        ext;
    logic [31:0] addr;
    logic        skip;
    logic [31:0] half_mask;
    logic [3:0]  half_be;
    logic [4:0]  byte_sh;
    logic [31:0] byte_mask;
    logic [3:0]  byte_be;
    logic [31:0] sym;
    logic [31:0] delta;
    logic [31:0] sym_ha;
    logic [15:0] cur_half;
    logic [7:0]  cur_byte;
    logic        full_eq;
    logic        half_eq;
    logic        byte_eq;
    logic [31:0] cur;

    function automatic logic [31:0] put_half(input logic [31:0] w, input logic hi_lane_low,
                                             input logic [15:0] h);
        logic [31:0] r;
        r = hi_lane_low ? {w[31:16], h} : {h, w[15:0]};
        return r;
    endfunction

    assign cur = i_cmd.current_word;

    always_comb begin
        case (i_cmd.opcode) inside
            OP_COND_PTR, OP_COND32, OP_COND16, OP_COND8: pw = 2'd2;
            OP_ADDR32, OP_ADDR16_LO, OP_ADDR16_HI, OP_ADDR16_HA, OP_REL24,
            OP_WRITE32, OP_WRITE16, OP_WRITE8, OP_BRANCH, OP_BRANCH_LINK: pw = 2'd1;
            default: pw = 2'd0;
        endcase
    end

    assign ext  = (i_cmd.short_address == MARK_EXTENDED);
    assign addr = ext ? i_cmd.long_address
                      : i_cfg.text_base + {8'd0, i_cmd.short_address};
    assign skip = ext ? (i_cfg.first_pass ? (addr >= i_cfg.split_address)
                                          : (addr < i_cfg.split_address))
                      : !i_cfg.first_pass;

    assign half_mask = addr[1] ? 32'h0000_FFFF : 32'hFFFF_0000;
    assign half_be   = addr[1] ? 4'b0011 : 4'b1100;
    assign byte_sh   = {~addr[1:0], 3'b000};
    assign byte_mask = 32'h0000_00FF << byte_sh;
    assign byte_be   = 4'b1000 >> addr[1:0];

    assign sym    = i_cmd.payload_value[31] ? i_cmd.payload_value
                                            : i_cfg.text_base + i_cmd.payload_value;
    assign delta  = sym - addr;
    assign sym_ha = sym + HA_ROUND;

    assign cur_half = addr[1] ? cur[15:0] : cur[31:16];
    assign cur_byte = 8'((cur & byte_mask) >> byte_sh);
    assign full_eq  = (cur == i_cmd.payload_original);
    assign half_eq  = (cur_half == i_cmd.payload_original[15:0]);
    assign byte_eq  = (cur_byte == i_cmd.payload_original[7:0]);

    always_comb begin
        o_res.status         = ST_APPLIED;
        o_res.write_enable   = 1'b0;
        o_res.target_address = addr;
        o_res.write_data     = cur;
        o_res.byte_enable    = 4'b0000;
        o_res.payload_words  = pw;
        if (pw == 2'd0) begin
            o_res.status         = ST_UNKNOWN;
            o_res.target_address = '0;
        end else if (skip) begin
            o_res.status = ST_SKIPPED;
        end else begin
            case (i_cmd.opcode)
                OP_ADDR32: begin
                    o_res.write_enable = 1'b1;
                    o_res.write_data   = sym;
                    o_res.byte_enable  = 4'b1111;
                end
                OP_ADDR16_LO: begin
                    o_res.write_enable = 1'b1;
                    o_res.write_data   = put_half(cur, addr[1], sym[15:0]);
                    o_res.byte_enable  = half_be;
                end
                OP_ADDR16_HI: begin
                    o_res.write_enable = 1'b1;
                    o_res.write_data   = put_half(cur, addr[1], sym[31:16]);
                    o_res.byte_enable  = half_be;
                end
                OP_ADDR16_HA: begin
                    o_res.write_enable = 1'b1;
                    o_res.write_data   = put_half(cur, addr[1], sym_ha[31:16]);
                    o_res.byte_enable  = half_be;
                end
                OP_REL24: begin
                    o_res.write_enable = 1'b1;
                    o_res.write_data   = (cur & KEEP_BITS) | (delta & DISP_BITS);
                    o_res.byte_enable  = 4'b1111;
                end
                OP_WRITE32: begin
                    o_res.write_enable = 1'b1;
                    o_res.write_data   = i_cmd.payload_value;
                    o_res.byte_enable  = 4'b1111;
                end
                OP_WRITE16: begin
                    o_res.write_enable = 1'b1;
                    o_res.write_data   = put_half(cur, addr[1], i_cmd.payload_value[15:0]);
                    o_res.byte_enable  = half_be;
                end
                OP_WRITE8: begin
                    o_res.write_enable = 1'b1;
                    o_res.write_data   = (cur & ~byte_mask)
                                       | ({24'd0, i_cmd.payload_value[7:0]} << byte_sh);
                    o_res.byte_enable  = byte_be;
                end
                OP_COND_PTR: begin
                    if (full_eq) begin
                        o_res.write_enable = 1'b1;
                        o_res.write_data   = sym;
                        o_res.byte_enable  = 4'b1111;
                    end
                end
                OP_COND32: begin
                    if (full_eq) begin
                        o_res.write_enable = 1'b1;
                        o_res.write_data   = i_cmd.payload_value;
                        o_res.byte_enable  = 4'b1111;
                    end
                end
                OP_COND16: begin
                    if (half_eq) begin
                        o_res.write_enable = 1'b1;
                        o_res.write_data   = (cur & ~half_mask)
                                           | put_half(32'd0, addr[1],
                                                      i_cmd.payload_value[15:0]);
                        o_res.byte_enable  = half_be;
                    end
                end
                OP_COND8: begin
                    if (byte_eq) begin
                        o_res.write_enable = 1'b1;
                        o_res.write_data   = (cur & ~byte_mask)
                                           | ({24'd0, i_cmd.payload_value[7:0]} << byte_sh);
                        o_res.byte_enable  = byte_be;
                    end
                end
                OP_BRANCH: begin
                    o_res.write_enable = 1'b1;
                    o_res.write_data   = (INSN_B & KEEP_BITS) | (delta & DISP_BITS);
                    o_res.byte_enable  = 4'b1111;
                end
                default: begin
                    o_res.write_enable = 1'b1;
                    o_res.write_data   = (INSN_BL & KEEP_BITS) | (delta & DISP_BITS);
                    o_res.byte_enable  = 4'b1111;
                end
            endcase
        end
    end

endmodule

// ===== rtl/relocation_patch_command_apply_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Relocation patch command apply: top level
// Commands enter on the s_axis channel, one per beat; each yields one result
// beat on m_axis with status, target, merged word, lanes and payload count.
// Registers text_base, split_address and first_pass are set through the
// i_cfg_* write port (index 0, 1, 2); the user must do so only while no
// command is in flight, as the block itself does not enforce it. A command
// passes an input register, then the merge logic, then the result register.
// One command is accepted every cycle while m_axis does not stall; the
// throughput of one beat per cycle is set by the single merge stage between
// the two registers. When m_axis stalls, the result register holds and the
// input register still takes one more beat; s_axis_tready drops once both
// are full. Reset empties both registers and loads the register defaults
// (text_base 0, split_address 0x8050BF50, first_pass 1).
// ----------------------------------------------------------------------------
module relocation_patch_command_apply_top
    import rpca_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [1:0]               i_cfg_index,
    input  logic [31:0]              i_cfg_wdata,
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    // opcode, short_address, long_address, payload_value, payload_original,
    // current_word
    input  logic [IN_TDATA_W-1:0]    s_axis_tdata,
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    // target_address, write_data, byte_enable, payload_words, zero pad
    output logic [OUT_TDATA_W-1:0]   m_axis_tdata,
    // status, write_enable
    output logic [OUT_TUSER_W-1:0]   m_axis_tuser
);

    t_cfg r_cfg;
    logic r_in_valid;
    t_cmd r_cmd;
    logic r_out_valid;
    t_res r_res;
    t_res n_res;
    logic out_ready;
    logic in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.text_base     <= TEXT_BASE_RST;
            r_cfg.split_address <= SPLIT_ADDR_RST;
            r_cfg.first_pass    <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_TEXT_BASE:  r_cfg.text_base     <= i_cfg_wdata;
                CFG_SPLIT_ADDR: r_cfg.split_address <= i_cfg_wdata;
                CFG_FIRST_PASS: r_cfg.first_pass    <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    assign out_ready     = !r_out_valid || m_axis_tready;
    assign in_ready      = !r_in_valid || out_ready;
    assign s_axis_tready = in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_ready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (out_ready) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && s_axis_tvalid) begin
            r_cmd <= t_cmd'(s_axis_tdata);
        end
        if (out_ready && r_in_valid) begin
            r_res <= n_res;
        end
    end

    rpca_merge u_merge (
        .i_cfg (r_cfg),
        .i_cmd (r_cmd),
        .o_res (n_res)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'b00, r_res.payload_words, r_res.byte_enable,
                            r_res.write_data, r_res.target_address};
    assign m_axis_tuser  = {r_res.write_enable, r_res.status};

endmodule
